// File: rtl/core/morse_char_queue_encoder_macros.svh
// assertion macros for the keyer queue encoder, used by the mcqe_queue module
`ifndef MORSE_CHAR_QUEUE_ENCODER_MACROS_SVH
`define MORSE_CHAR_QUEUE_ENCODER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define MCQE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define MCQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mcqe_pkg.sv
// types, codes and the morse lookup table for the keyer queue encoder
`timescale 1ns / 1ps
package mcqe_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CHAR_W          = 8;
  localparam int SIGN_W          = 2;
  localparam int MAX_SIGNS       = 7;
  localparam int PAT_W           = SIGN_W * MAX_SIGNS;
  localparam int CNT_W           = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  // sign codes
  localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_DIT  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_DASH = 2'd2;
  localparam logic [SIGN_W-1:0] SIGN_GAP  = 2'd3;

  // item kinds
  localparam logic FUNC_PUSH    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // register word indexes
  localparam logic REG_KEYER_EN = 1'b0;

  // character codes with special handling
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } qstat_t;

  typedef struct packed {
    logic             known;
    logic [CNT_W-1:0] len;
    logic [5:0]       bits;
  } mchar_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [PAT_W-1:0] signs;
  } pattern_t;

  function automatic mchar_t mc(input logic [CNT_W-1:0] len, input logic [5:0] bits);
    mchar_t r;
    r.known = 1'b1;
    r.len   = len;
    r.bits  = bits;
    return r;
  endfunction

  // dot/dash shape, first sign in the top used bit, dash as one
  function automatic mchar_t char_shape(input logic [CHAR_W-1:0] code);
    mchar_t r;
    r = '0;
    case (code)
      8'h41: r = mc(3'd2, 6'b000001);
      8'h42: r = mc(3'd4, 6'b001000);
      8'h43: r = mc(3'd4, 6'b001010);
      8'h44: r = mc(3'd3, 6'b000100);
      8'h45: r = mc(3'd1, 6'b000000);
      8'h46: r = mc(3'd4, 6'b000010);
      8'h47: r = mc(3'd3, 6'b000110);
      8'h48: r = mc(3'd4, 6'b000000);
      8'h49: r = mc(3'd2, 6'b000000);
      8'h4A: r = mc(3'd4, 6'b000111);
      8'h4B: r = mc(3'd3, 6'b000101);
      8'h4C: r = mc(3'd4, 6'b000100);
      8'h4D: r = mc(3'd2, 6'b000011);
      8'h4E: r = mc(3'd2, 6'b000010);
      8'h4F: r = mc(3'd3, 6'b000111);
      8'h50: r = mc(3'd4, 6'b000110);
      8'h51: r = mc(3'd4, 6'b001101);
      8'h52: r = mc(3'd3, 6'b000010);
      8'h53: r = mc(3'd3, 6'b000000);
      8'h54: r = mc(3'd1, 6'b000001);
      8'h55: r = mc(3'd3, 6'b000001);
      8'h56: r = mc(3'd4, 6'b000001);
      8'h57: r = mc(3'd3, 6'b000011);
      8'h58: r = mc(3'd4, 6'b001001);
      8'h59: r = mc(3'd4, 6'b001011);
      8'h5A: r = mc(3'd4, 6'b001100);
      8'h30: r = mc(3'd5, 6'b011111);
      8'h31: r = mc(3'd5, 6'b001111);
      8'h32: r = mc(3'd5, 6'b000111);
      8'h33: r = mc(3'd5, 6'b000011);
      8'h34: r = mc(3'd5, 6'b000001);
      8'h35: r = mc(3'd5, 6'b000000);
      8'h36: r = mc(3'd5, 6'b010000);
      8'h37: r = mc(3'd5, 6'b011000);
      8'h38: r = mc(3'd5, 6'b011100);
      8'h39: r = mc(3'd5, 6'b011110);
      8'h26: r = mc(3'd5, 6'b001000);
      8'h2B: r = mc(3'd5, 6'b001010);
      8'h3D: r = mc(3'd5, 6'b010001);
      8'h2F: r = mc(3'd5, 6'b010010);
      8'h28: r = mc(3'd5, 6'b010110);
      8'h3F: r = mc(3'd6, 6'b001100);
      8'h5F: r = mc(3'd6, 6'b001101);
      8'h22: r = mc(3'd6, 6'b010010);
      8'h2E: r = mc(3'd6, 6'b010101);
      8'h40: r = mc(3'd6, 6'b011010);
      8'h3B: r = mc(3'd6, 6'b101010);
      8'h21: r = mc(3'd6, 6'b101100);
      8'h29: r = mc(3'd6, 6'b101110);
      8'h2C: r = mc(3'd6, 6'b110011);
      8'h3A: r = mc(3'd6, 6'b111000);
      8'hDC: r = mc(3'd4, 6'b000011);
      8'hC4: r = mc(3'd4, 6'b000101);
      8'hD6: r = mc(3'd4, 6'b001110);
      8'hC9: r = mc(3'd5, 6'b010100);
      default: r = '0;
    endcase
    return r;
  endfunction

  // full sign pattern with trailing gap, next sign in the low bits; n of zero means unknown
  function automatic pattern_t lookup_pattern(input logic [CHAR_W-1:0] code);
    pattern_t         p;
    mchar_t           s;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] idx;
    p = '0;
    s = char_shape(code);
    if (code == CHAR_SPACE) begin
      p.n     = 3'd2;
      p.signs = {{(PAT_W-2*SIGN_W){1'b0}}, SIGN_GAP, SIGN_GAP};
    end else if (s.known) begin
      p.n = s.len + 3'd1;
      for (int i = 0; i < MAX_SIGNS; i++) begin
        pos = CNT_W'(i);
        idx = s.len - 3'd1 - pos;
        if (pos < s.len) begin
          p.signs[SIGN_W*i +: SIGN_W] = (idx < 3'd6 && s.bits[idx]) ? SIGN_DASH : SIGN_DIT;
        end else if (pos == s.len) begin
          p.signs[SIGN_W*i +: SIGN_W] = SIGN_GAP;
        end
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/mcqe_queue.sv
// ring queue of character codes with a registered head read
`timescale 1ns / 1ps
`include "morse_char_queue_encoder_macros.svh"
module mcqe_queue
  import mcqe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [CHAR_W-1:0] push_char,
  input  logic              pop,
  output logic [CHAR_W-1:0] head_char,
  output qstat_t            stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [CHAR_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, wr_inc;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt, rd_inc;
  logic [CHAR_W-1:0] head_r;

  // wrapping increments
  assign wr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_inc : rd_ptr_r;

  // occupancy flags, one slot always kept free
  assign stat.full  = (wr_inc == rd_ptr_r);
  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.last  = (rd_inc == wr_ptr_r);

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_char;
    end
  end

  // head read at the next read pointer, new data forwarded on a same-slot write
  always_ff @(posedge clk) begin
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_char;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head_char = head_r;

  `MCQE_ASSERT_ALWAYS(a_no_pop_empty, !(pop && stat.empty), "pop from empty queue")
  `MCQE_ASSERT_ALWAYS(a_no_push_full, !(push && stat.full), "push into full queue")
  `MCQE_ASSERT_NEXT(a_pop_moves, pop, rd_ptr_r != $past(rd_ptr_r), "read pointer stuck on pop")
  `MCQE_ASSERT_NEXT(a_push_moves, push, wr_ptr_r != $past(wr_ptr_r), "write pointer stuck on push")

endmodule

// File: rtl/core/mcqe_sign.sv
// sign sequencer: holds the current pattern and fetches the next character
`timescale 1ns / 1ps
module mcqe_sign
  import mcqe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req,
  input  logic [CHAR_W-1:0] head_char,
  input  qstat_t            stat,
  output logic              pop,
  output logic [SIGN_W-1:0] element,
  output logic              empty_flag
);

  logic [PAT_W-1:0] signs_r, signs_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  pattern_t         pat;
  logic             have_signs;

  assign pat        = lookup_pattern(head_char);
  assign have_signs = (left_r != '0);

  // next sign, or a fetch from the queue once the pattern is used up
  always_comb begin
    signs_nxt  = signs_r;
    left_nxt   = left_r;
    pop        = 1'b0;
    element    = SIGN_NONE;
    empty_flag = 1'b0;
    if (req) begin
      if (have_signs) begin
        element   = signs_r[SIGN_W-1:0];
        signs_nxt = signs_r >> SIGN_W;
        left_nxt  = left_r - 1'b1;
      end else begin
        empty_flag = stat.empty || stat.last;
        if (!stat.empty) begin
          pop = 1'b1;
          if (pat.n != '0) begin
            element   = pat.signs[SIGN_W-1:0];
            signs_nxt = pat.signs >> SIGN_W;
            left_nxt  = pat.n - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signs_r <= '0;
      left_r  <= '0;
    end else begin
      signs_r <= signs_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: rtl/core/morse_char_queue_encoder.sv
// top level of the keyer queue encoder: handshakes, register port, result register
//
//   port group  dir  beat contents
//   in_*        in   tdata: char_code[7:0], timer_free[8]; tuser: func[0]
//   out_*       out  tdata: accepted[0], element[2:1], queue_empty[3]
//   apb         in   register 0 at byte 0: keyer_enabled in bit 0
//
// one beat per cycle while in_tready is high; each beat is decided in the cycle it is taken and its result
// sits in the output register the next cycle
// the queue head comes from a registered read of the character memory, addressed
// with the next read pointer so it is ready for the following beat
// rst_n is synchronous; it clears pointers, the pattern, the enable and the result valid
// in_tready drops only while a result is held and out_tready is low
`timescale 1ns / 1ps
module morse_char_queue_encoder
  import mcqe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // char_code[7:0], timer_free[8], zeros above
  input  logic [0:0]            in_tuser,   // func[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // accepted[0], element[2:1], queue_empty[3]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic              keyer_en_r;
  logic              cfg_wr;
  logic              beat;
  logic              func;
  logic [CHAR_W-1:0] char_code;
  logic              timer_free;
  logic              push, req, pop;
  logic [CHAR_W-1:0] head_char;
  qstat_t            stat;
  logic [SIGN_W-1:0] element;
  logic              empty_flag;
  logic              out_valid_r;
  logic              accepted_r;
  logic [SIGN_W-1:0] element_r;
  logic              empty_r;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_KEYER_EN);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_KEYER_EN) ?
                  {{(CFG_DATA_W-1){1'b0}}, keyer_en_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyer_en_r <= 1'b0;
    end else if (cfg_wr) begin
      keyer_en_r <= pwdata[0];
    end
  end

  // beat decode
  assign in_tready  = !out_valid_r || out_tready;
  assign beat       = in_tvalid && in_tready;
  assign func       = in_tuser[0];
  assign char_code  = in_tdata[CHAR_W-1:0];
  assign timer_free = in_tdata[CHAR_W];
  assign push       = beat && (func == FUNC_PUSH) && !stat.full;
  assign req        = beat && (func == FUNC_REQUEST) && keyer_en_r && timer_free;

  mcqe_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_char (char_code),
    .pop       (pop),
    .head_char (head_char),
    .stat      (stat)
  );

  mcqe_sign u_sign (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .head_char  (head_char),
    .stat       (stat),
    .pop        (pop),
    .element    (element),
    .empty_flag (empty_flag)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (beat) begin
      accepted_r <= push;
      element_r  <= element;
      empty_r    <= empty_flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, empty_r, element_r, accepted_r};

endmodule

// File: tb/morse_sign_compare.sv
// predictor and result comparison for the keyer queue encoder bench
`timescale 1ns / 1ps
module morse_sign_compare
  import mcqe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,   // char_code[7:0], timer_free[8], zeros above
  input  logic [0:0]            in_tuser,   // func[0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // accepted[0], element[2:1], queue_empty[3]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  localparam logic [CFG_ADDR_W-1:0] KEYER_EN_ADDR = CFG_ADDR_W'(4 * int'(REG_KEYER_EN));

  // result beat fields, lowest bit last
  typedef struct packed {
    logic              queue_empty;
    logic [SIGN_W-1:0] element;
    logic              accepted;
  } sign_beat_t;

  // predicted keyer state
  logic [CHAR_W-1:0] char_ring [QUEUE_DEPTH];
  int unsigned       wr_idx;
  int unsigned       rd_idx;
  logic [PAT_W-1:0]  signs_pending;
  logic [CNT_W-1:0]  signs_count;
  logic              keyer_on;

  sign_beat_t  expected_beats [$];
  int unsigned err_count = 0;

  // dot/dash text of each known character, empty when unknown
  function automatic string morse_text(input logic [CHAR_W-1:0] ch);
    case (ch)
      "A": return ".- ";     "B": return "-... ";   "C": return "-.-. ";
      "D": return "-.. ";    "E": return ". ";      "F": return "..-. ";
      "G": return "--. ";    "H": return ".... ";   "I": return ".. ";
      "J": return ".--- ";   "K": return "-.- ";    "L": return ".-.. ";
      "M": return "-- ";     "N": return "-. ";     "O": return "--- ";
      "P": return ".--. ";   "Q": return "--.- ";   "R": return ".-. ";
      "S": return "... ";    "T": return "- ";      "U": return "..- ";
      "V": return "...- ";   "W": return ".-- ";    "X": return "-..- ";
      "Y": return "-.-- ";   "Z": return "--.. ";
      "0": return "----- ";  "1": return ".---- ";  "2": return "..--- ";
      "3": return "...-- ";  "4": return "....- ";  "5": return "..... ";
      "6": return "-.... ";  "7": return "--... ";  "8": return "---.. ";
      "9": return "----. ";
      " ": return "  ";      "&": return ".-... ";  "+": return ".-.-. ";
      "=": return "-...- ";  "/": return "-..-. ";  "(": return "-.--. ";
      "?": return "..--.. "; "_": return "..--.- "; "\"": return ".-..-. ";
      ".": return ".-.-.- "; "@": return ".--.-. "; ";": return "-.-.-. ";
      "!": return "-.--.. "; ")": return "-.---. "; ",": return "--..-- ";
      ":": return "---... ";
      8'hDC: return "..-- ";  8'hC4: return ".-.- ";
      8'hD6: return "---. ";  8'hC9: return "-.-.. ";
      default: return "";
    endcase
  endfunction

  // sign codes packed two bits each, first sign lowest; returns the sign count
  function automatic logic [CNT_W-1:0] pattern_of(input logic [CHAR_W-1:0] ch,
                                                  output logic [PAT_W-1:0] signs_out);
    string            txt;
    int               n;
    logic [SIGN_W-1:0] s;
    txt       = morse_text(ch);
    signs_out = '0;
    n         = 0;
    while (n < txt.len() && n < MAX_SIGNS) begin
      if (txt[n] == ".") s = SIGN_DIT;
      else if (txt[n] == "-") s = SIGN_DASH;
      else s = SIGN_GAP;
      signs_out[SIGN_W*n +: SIGN_W] = s;
      n++;
    end
    return CNT_W'(n);
  endfunction

  function automatic logic [SIGN_W-1:0] pop_next_sign();
    logic [SIGN_W-1:0] s;
    s             = signs_pending[SIGN_W-1:0];
    signs_pending = signs_pending >> SIGN_W;
    signs_count   = signs_count - 1'b1;
    return s;
  endfunction

  // one accepted input beat through the predicted keyer
  function automatic sign_beat_t keyer_step(input logic fn, input logic [CHAR_W-1:0] ch,
                                            input logic tfree);
    sign_beat_t        r;
    int unsigned       nxt;
    logic [CHAR_W-1:0] head;
    logic [PAT_W-1:0]  pat;
    logic [CNT_W-1:0]  n;
    r = '0;
    if (fn == FUNC_PUSH) begin
      nxt = (wr_idx + 1) % QUEUE_DEPTH;
      if (nxt != rd_idx) begin
        char_ring[wr_idx] = ch;
        wr_idx            = nxt;
        r.accepted        = 1'b1;
      end
    end else if (keyer_on && tfree) begin
      if (signs_count != 0) begin
        r.element = pop_next_sign();
      end else begin
        if (rd_idx != wr_idx) begin
          head   = char_ring[rd_idx];
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          n      = pattern_of(head, pat);
          if (n != 0) begin
            signs_pending = pat;
            signs_count   = n;
            r.element     = pop_next_sign();
          end
        end
        if (rd_idx == wr_idx) r.queue_empty = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      err_count++;
    end
  endtask

  // track config writes, predict on input beats, compare on output beats
  always @(posedge clk) begin
    sign_beat_t got;
    sign_beat_t want;
    if (!rst_n) begin
      wr_idx        = 0;
      rd_idx        = 0;
      signs_pending = '0;
      signs_count   = '0;
      keyer_on      = 1'b0;
      expected_beats.delete();
      mismatches  <= err_count;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat expected none got %h", $time, got);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("element", want.element, got.element);
          check_field("queue_empty", want.queue_empty, got.queue_empty);
        end
      end
      if (psel && penable && pwrite && pready && paddr == KEYER_EN_ADDR) begin
        keyer_on = pwdata[0];
      end
      if (in_tvalid && in_tready) begin
        expected_beats.push_back(keyer_step(in_tuser[0], in_tdata[7:0], in_tdata[8]));
      end
      mismatches  <= err_count;
      outstanding <= expected_beats.size();
    end
  end

endmodule

// File: tb/tb.sv
// top of the keyer queue encoder bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import mcqe_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] KEYER_EN_ADDR = CFG_ADDR_W'(4 * int'(REG_KEYER_EN));

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // char_code[7:0], timer_free[8], zeros above
  logic [0:0]            in_tuser;   // func[0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // accepted[0], element[2:1], queue_empty[3]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  bit          long_hold    = 1'b0;
  string       morse_chars  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 &+=/(?_\".@;!),:";

  morse_char_queue_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  morse_sign_compare sign_compare (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall run ends the test when no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random back-pressure bursts plus one long hold-off on request
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // one input beat, with an optional idle burst ahead of it; tvalid stays up afterwards
  task automatic send_beat(input logic fn, input logic [CHAR_W-1:0] ch, input logic tfree);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {7'd0, tfree, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly known characters, some accented, some arbitrary bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return morse_chars[$urandom_range(0, morse_chars.len() - 1)];
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 8'hDC;
        1: return 8'hC4;
        2: return 8'hD6;
        default: return 8'hC9;
      endcase
    end
    return CHAR_W'($urandom);
  endfunction

  task automatic send_mix(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        send_beat(FUNC_PUSH, pick_char(), 1'($urandom_range(0, 1)));
      end else begin
        send_beat(FUNC_REQUEST, CHAR_W'($urandom), $urandom_range(0, 99) < 85);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keyer off after reset: request yields nothing, push still lands
    send_beat(FUNC_REQUEST, 8'h00, 1'b1);
    send_beat(FUNC_PUSH, "E", 1'b0);
    wait_drained();
    write_reg(KEYER_EN_ADDR, 32'd1);
    // busy timer, then E as dit and gap, then a fetch from an empty queue
    send_beat(FUNC_REQUEST, 8'hFF, 1'b0);
    repeat (3) send_beat(FUNC_REQUEST, 8'h00, 1'b1);
    // space, unknown byte and the repaired I, L, V patterns
    send_beat(FUNC_PUSH, CHAR_SPACE, 1'b1);
    send_beat(FUNC_PUSH, 8'hFF, 1'b0);
    send_beat(FUNC_PUSH, "I", 1'b1);
    send_beat(FUNC_PUSH, "L", 1'b0);
    send_beat(FUNC_PUSH, "V", 1'b1);
    repeat (17) send_beat(FUNC_REQUEST, 8'h00, 1'b1);

    // balanced traffic with a full pause halfway
    wait_drained();
    write_reg(KEYER_EN_ADDR, 32'd1);
    send_mix(250, 22);
    wait_drained();
    send_mix(250, 22);

    // keyer off: pushes fill the queue until it refuses
    wait_drained();
    write_reg(KEYER_EN_ADDR, 32'd0);
    send_mix(150, 80);

    // keyer on, mostly requests: drain to empty, with one long output hold-off
    wait_drained();
    write_reg(KEYER_EN_ADDR, 32'd1);
    send_mix(100, 10);
    long_hold = 1'b1;
    send_mix(300, 10);

    wait_drained();
    write_reg(KEYER_EN_ADDR, 32'd1);
    send_mix(450, 25);

    // closing stretch with no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_mix(300, 22);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
